// ===== design/ascm_pkg.sv =====
// shared types and constants for the adc scan and charge monitor
// no dependencies; imported by ascm_scale and adc_scan_and_charge_monitor
`default_nettype none

package ascm_pkg;

    // channel numbers of the scan
    localparam logic [1:0] CH_CHARGE     = 2'd0;
    localparam logic [1:0] CH_CURRENT    = 2'd1;
    localparam logic [1:0] CH_BATTERY    = 2'd2;
    localparam logic [1:0] CH_THERMISTOR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE  = 2'd1;
    localparam logic [1:0] CFG_HOLDOFF   = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    // reset values of the configuration registers
    localparam logic [10:0] THRESHOLD_RESET = 11'd60;
    localparam logic [9:0]  DEBOUNCE_RESET  = 10'd1000;
    localparam logic [9:0]  HOLDOFF_RESET   = 10'd500;

    // timeout: more than this many ticks without a conversion
    localparam logic [2:0] MISSED_LIMIT = 3'd2;

    // sample * 4 / 55 == (sample * 76261) >> 20, exact for 14-bit samples
    localparam logic [30:0] CUR_RECIP = 31'd76261;
    localparam int          CUR_SHIFT = 20;

    // value / 5 == (value * 26215) >> 17, exact for 15-bit values
    localparam logic [29:0] DIV5_RECIP = 30'd26215;
    localparam int          DIV5_SHIFT = 17;

    typedef struct packed {
        logic        conversion_done;
        logic [13:0] adc_sample;
        logic        battery_monitor_on;
        logic        charging_complete_pin;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  channel_select;
        logic        start_conversion;
        logic        force_done;
        logic [14:0] charge_level;
        logic [10:0] charge_current_ma;
        logic [12:0] battery_level;
        logic [11:0] thermistor_level;
        logic        charging;
        logic        charge_disable;
    } out_item_t;

    // scaled forms of one sample, one per channel
    typedef struct packed {
        logic [14:0] charge_level;
        logic [10:0] current_ma;
        logic [12:0] battery_level;
        logic [11:0] thermistor_level;
    } scale_t;

endpackage : ascm_pkg

`default_nettype wire

// ===== design/ascm_scale.sv =====
// per-channel scaling of one raw adc sample: a doubling, or a multiply by a constant reciprocal
// depends on ascm_pkg
`default_nettype none

module ascm_scale (
    input  wire logic [13:0]     sample,
    input  wire logic [1:0]      channel,
    input  wire logic            monitor_on,
    output ascm_pkg::scale_t     scaled
);
    import ascm_pkg::*;

    logic [30:0] cur_prod;
    logic [14:0] div5_in;
    logic [29:0] div5_prod;

    // times 4 over 55
    assign cur_prod = 31'(sample) * CUR_RECIP;

    // one shared divide by five: battery without divider takes sample * 2
    always_comb
    begin
        if (channel == CH_BATTERY && !monitor_on)
        begin
            div5_in = {sample, 1'b0};
        end
        else
        begin
            div5_in = {1'b0, sample};
        end
    end

    assign div5_prod = 30'(div5_in) * DIV5_RECIP;

    assign scaled.charge_level     = {sample, 1'b0};
    assign scaled.current_ma       = cur_prod[CUR_SHIFT +: 11];
    assign scaled.battery_level    = div5_prod[DIV5_SHIFT +: 13];
    assign scaled.thermistor_level = div5_prod[DIV5_SHIFT +: 12];

endmodule : ascm_scale

`default_nettype wire

// ===== design/adc_scan_and_charge_monitor.sv =====
// a request is registered in the input stage when it is accepted and its result is registered
// in the result stage, from which it can be taken while out_valid is high
// throughput: one request per cycle while out_stall is low; the scan and charge state updates in one pass
// reset: rst_n clears all scan and charge state to zero, empties both stages and loads
// the threshold, debounce and hold-off registers with 60, 1000 and 500
`default_nettype none

module adc_scan_and_charge_monitor (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // request channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire ascm_pkg::in_item_t                    in_data,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output ascm_pkg::out_item_t                        out_data,
    // configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [ascm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [ascm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ascm_pkg::*;

    // configuration registers
    logic [10:0] threshold_reg;
    logic [9:0]  debounce_limit_reg;
    logic [9:0]  holdoff_ticks_reg;

    // input stage
    logic        in_valid_reg;
    in_item_t    in_item_reg;

    // result stage
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;

    // scan state
    logic [1:0]  channel_reg;
    logic [1:0]  channel_next;
    logic        error_reg;
    logic        error_next;
    logic        settle_reg;
    logic        settle_next;
    logic [1:0]  missed_reg;
    logic [1:0]  missed_next;

    // held readings
    logic [14:0] charge_level_reg;
    logic [14:0] charge_level_next;
    logic [10:0] current_reg;
    logic [10:0] current_next;
    logic [12:0] battery_reg;
    logic [12:0] battery_next;
    logic [11:0] thermistor_reg;
    logic [11:0] thermistor_next;

    // charge monitor state
    logic [9:0]  debounce_reg;
    logic [9:0]  debounce_next;
    logic [9:0]  holdoff_reg;
    logic [9:0]  holdoff_next;
    logic        disable_reg;
    logic        disable_next;

    // pass control
    logic        advance;
    scale_t      scaled;
    logic        start_conv;
    logic        forced;
    logic        over;
    logic        charging;
    logic [2:0]  missed_inc;
    logic [10:0] debounce_inc;
    logic [9:0]  holdoff_dec;
    logic        disable_mid;

    // the held request is processed whenever the result register is free or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    // the input register refills in the same cycle it is processed
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // configuration writes; index three is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= THRESHOLD_RESET;
            debounce_limit_reg <= DEBOUNCE_RESET;
            holdoff_ticks_reg  <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg      <= cfg_data;
                CFG_DEBOUNCE:  debounce_limit_reg <= cfg_data[9:0];
                CFG_HOLDOFF:   holdoff_ticks_reg  <= cfg_data[9:0];
                default:       ;
            endcase
        end
    end

    // sample scaling for every channel, one chosen below
    ascm_scale u_scale (
        .sample     (in_item_reg.adc_sample),
        .channel    (channel_reg),
        .monitor_on (in_item_reg.battery_monitor_on),
        .scaled     (scaled)
    );

    // adc scan: store a sample, restart after settle/error, count a missed tick or force a timeout
    always_comb
    begin
        channel_next      = channel_reg;
        error_next        = error_reg;
        settle_next       = settle_reg;
        missed_next       = missed_reg;
        charge_level_next = charge_level_reg;
        current_next      = current_reg;
        battery_next      = battery_reg;
        thermistor_next   = thermistor_reg;
        start_conv        = 1'b0;
        forced            = 1'b0;
        missed_inc        = {1'b0, missed_reg} + 3'd1;

        if (in_item_reg.conversion_done)
        begin
            if (!error_reg && !settle_reg)
            begin
                case (channel_reg)
                    CH_CHARGE:     charge_level_next = scaled.charge_level;
                    CH_CURRENT:    current_next      = scaled.current_ma;
                    CH_BATTERY:    battery_next      = scaled.battery_level;
                    CH_THERMISTOR: thermistor_next   = scaled.thermistor_level;
                    default:       ;
                endcase
                // channel wraps from three back to zero
                channel_next = channel_reg + 2'd1;
                settle_next  = 1'b1;
            end
            else
            begin
                // throw away this conversion and start a fresh one
                start_conv  = 1'b1;
                settle_next = 1'b0;
                error_next  = 1'b0;
            end
        end
        else
        begin
            // missed count is not cleared by a completed conversion
            if (missed_inc > MISSED_LIMIT)
            begin
                forced       = 1'b1;
                channel_next = CH_CHARGE;
                error_next   = 1'b1;
                missed_next  = 2'd0;
            end
            else
            begin
                missed_next = missed_inc[1:0];
            end
        end
    end

    // charge monitor works on the freshly updated current
    always_comb
    begin
        over         = current_next > threshold_reg;
        charging     = !in_item_reg.charging_complete_pin || over;
        holdoff_dec  = (holdoff_reg != 10'd0) ? holdoff_reg - 10'd1 : 10'd0;
        debounce_inc = {1'b0, debounce_reg} + 11'd1;
        holdoff_next = holdoff_dec;
        disable_mid  = disable_reg;

        if (over && in_item_reg.charging_complete_pin)
        begin
            // current while the charger says complete: debounce then trip
            if (debounce_inc > {1'b0, debounce_limit_reg})
            begin
                disable_mid   = 1'b1;
                debounce_next = 10'd0;
                holdoff_next  = holdoff_ticks_reg;
            end
            else
            begin
                debounce_next = debounce_inc[9:0];
            end
        end
        else
        begin
            debounce_next = 10'd0;
        end

        // expired hold-off re-enables charging, also a zero hold-off on the trip tick
        disable_next = (holdoff_next == 10'd0) ? 1'b0 : disable_mid;
    end

    // result assembled from the updated state
    always_comb
    begin
        out_item_next.channel_select    = channel_next;
        out_item_next.start_conversion  = start_conv;
        out_item_next.force_done        = forced;
        out_item_next.charge_level      = charge_level_next;
        out_item_next.charge_current_ma = current_next;
        out_item_next.battery_level     = battery_next;
        out_item_next.thermistor_level  = thermistor_next;
        out_item_next.charging          = charging;
        out_item_next.charge_disable    = disable_next;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // scan and charge state, updated once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg      <= CH_CHARGE;
            error_reg        <= 1'b0;
            settle_reg       <= 1'b0;
            missed_reg       <= 2'd0;
            charge_level_reg <= 15'd0;
            current_reg      <= 11'd0;
            battery_reg      <= 13'd0;
            thermistor_reg   <= 12'd0;
            debounce_reg     <= 10'd0;
            holdoff_reg      <= 10'd0;
            disable_reg      <= 1'b0;
        end
        else if (advance)
        begin
            channel_reg      <= channel_next;
            error_reg        <= error_next;
            settle_reg       <= settle_next;
            missed_reg       <= missed_next;
            charge_level_reg <= charge_level_next;
            current_reg      <= current_next;
            battery_reg      <= battery_next;
            thermistor_reg   <= thermistor_next;
            debounce_reg     <= debounce_next;
            holdoff_reg      <= holdoff_next;
            disable_reg      <= disable_next;
        end
    end

endmodule : adc_scan_and_charge_monitor

`default_nettype wire
